@@ rtl/core/sfau_pkg.sv @@
// Shared types, constants and helpers for the single-precision arithmetic unit.
// No dependencies; every file of the unit imports this package.
package sfau_pkg;

  localparam int FRAC_W    = 23;
  localparam int MANT_W    = 24;
  localparam int EXP_W     = 11;
  localparam int PROD_W    = 48;
  localparam int NUM_W     = 47;
  localparam int DIV_STEPS = 47;
  localparam int NST       = DIV_STEPS + 2;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // One pipeline word: control, add/mul datapath and divider datapath
  typedef struct packed {
    logic                     vld;
    op_t                      op;
    logic                     sa;
    logic                     sb;
    logic                     sg;
    logic signed [EXP_W-1:0]  ex;
    logic [MANT_W-1:0]        xa;
    logic [MANT_W-1:0]        xb;
    logic [PROD_W-1:0]        am;
    logic                     zr;
    logic [FRAC_W-1:0]        frac;
    logic [31:0]              res;
    logic                     dz;
    logic [NUM_W-1:0]         num;
    logic [NUM_W-1:0]         quo;
    logic [MANT_W-1:0]        rem;
    logic [MANT_W-1:0]        dvsr;
  } pipe_t;

  // Count shifts needed to bring the leading one up to bit 23
  function automatic logic [4:0] lead_zeros(logic [MANT_W-1:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < MANT_W; i++) begin
      if (v[i]) n = 5'(MANT_W - 1 - i);
    end
    return n;
  endfunction

  // Clamp the biased exponent to 1..254 and assemble the word
  function automatic logic [31:0] pack_word(logic s, logic signed [EXP_W-1:0] e,
                                            logic [FRAC_W-1:0] f);
    logic [7:0] e8;
    if (e > 11'sd254) e8 = 8'd254;
    else if (e < 11'sd1) e8 = 8'd1;
    else e8 = e[7:0];
    return {s, e8, f};
  endfunction

endpackage

@@ rtl/core/sfau_div_step.sv @@
// One restoring division step: shift in a dividend bit, compare, subtract.
// Depends on sfau_pkg for mantissa widths.
module sfau_div_step
  import sfau_pkg::*;
(
  input  logic [MANT_W-1:0] rem_i,
  input  logic              bit_i,
  input  logic [MANT_W-1:0] dvsr_i,
  output logic [MANT_W-1:0] rem_o,
  output logic              q_o
);

  logic [MANT_W:0] trial;

  // Subtract the divisor when the partial remainder reaches it
  always_comb begin
    trial = {rem_i, bit_i};
    if (trial >= {1'b0, dvsr_i}) begin
      q_o   = 1'b1;
      rem_o = MANT_W'(trial - {1'b0, dvsr_i});
    end else begin
      q_o   = 1'b0;
      rem_o = trial[MANT_W-1:0];
    end
  end

endmodule

@@ rtl/core/single_float_arith_unit.sv @@
// Top level of the single-precision add/sub/mul/div unit: unpack, divider stages, pack.
// Depends on sfau_pkg and sfau_div_step.
//
//  channel | dir | handshake            | word
//  in_     | in  | in_tvalid/in_tready  | operation, operand_a, operand_b
//  out_    | out | out_tvalid/out_tready| result_word
//
// The pipe holds one unpack stage, 47 restoring divider stages (one quotient bit each),
// one quotient normalize stage and the output register. Add and multiply finish in the
// first stages and ride along to keep order. One word enters per cycle when not stalled.
// rst_n clears all valid bits synchronously. A stall on out_tready freezes every stage.
module single_float_arith_unit
  import sfau_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // operation[1:0], operand_a[33:2], operand_b[65:34], zeros
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // result_word[31:0]
);

  pipe_t             st_r   [NST];
  pipe_t             st_nxt [NST];
  logic [MANT_W-1:0] div_rem [DIV_STEPS];
  logic              div_q   [DIV_STEPS];
  logic              out_vld_r;
  logic [31:0]       out_data_r;
  logic [31:0]       out_data_nxt;
  logic              adv;

  assign adv        = !out_vld_r || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // Unpack operands, align for add, set up multiply and divide
  always_comb begin
    logic [31:0]       a;
    logic [31:0]       b;
    logic [7:0]        ea;
    logic [7:0]        eb;
    logic [7:0]        eb1;
    logic [MANT_W-1:0] ma;
    logic [MANT_W-1:0] mb;
    pipe_t             p;
    a    = in_tdata[33:2];
    b    = in_tdata[65:34];
    ea   = a[30:23];
    eb   = b[30:23];
    ma   = {|ea, a[22:0]};
    mb   = {|eb, b[22:0]};
    eb1  = (eb == 8'd0) ? 8'd1 : eb;
    p    = '0;
    p.vld = in_tvalid;
    p.op  = op_t'(in_tdata[1:0]);
    p.sa  = a[31];
    p.sb  = b[31] ^ (p.op == OP_SUB);
    p.sg  = a[31] ^ b[31];
    case (p.op)
      OP_ADD, OP_SUB: begin
        if (ea > eb) begin
          p.xa = ma;
          p.xb = mb >> (ea - eb);
          p.ex = $signed({3'b0, ea});
        end else begin
          p.xa = ma >> (eb - ea);
          p.xb = mb;
          p.ex = $signed({3'b0, eb});
        end
      end
      OP_MUL: begin
        p.xa = ma;
        p.xb = mb;
        if (ea == 8'd0 || eb == 8'd0) p.ex = '0;
        else p.ex = $signed({3'b0, ea}) + $signed({3'b0, eb}) - 11'sd127;
      end
      OP_DIV: begin
        p.dz   = (eb == 8'd0) && (b[22:0] == 23'd0);
        p.ex   = $signed({3'b0, ea}) - $signed({3'b0, eb1}) + 11'sd127;
        p.num  = {ma, 23'd0};
        p.dvsr = mb;
      end
      default: p.xa = ma;
    endcase
    st_nxt[0] = p;
  end

  // Divider stages; the first three also carry the add and multiply datapath
  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_stage
    sfau_div_step u_step (
      .rem_i  (st_r[j-1].rem),
      .bit_i  (st_r[j-1].num[NUM_W-1]),
      .dvsr_i (st_r[j-1].dvsr),
      .rem_o  (div_rem[j-1]),
      .q_o    (div_q[j-1])
    );

    always_comb begin
      pipe_t             p;
      logic [MANT_W:0]   m25;
      logic [MANT_W-1:0] m24;
      logic [4:0]        lz;
      logic signed [EXP_W-1:0] e;
      p     = st_r[j-1];
      m25   = '0;
      m24   = '0;
      lz    = '0;
      e     = p.ex;
      p.num = {p.num[NUM_W-2:0], 1'b0};
      p.quo = {p.quo[NUM_W-2:0], div_q[j-1]};
      p.rem = div_rem[j-1];
      // Add/subtract magnitudes or multiply mantissas
      if (j == 1) begin
        if (p.op == OP_MUL) begin
          p.am = p.xa * p.xb;
        end else if (p.op != OP_DIV) begin
          if (p.sa == p.sb) begin
            m25  = {1'b0, p.xa} + {1'b0, p.xb};
            p.sg = p.sa;
          end else if (p.xa >= p.xb) begin
            m25  = {1'b0, p.xa} - {1'b0, p.xb};
            p.sg = p.sa;
          end else begin
            m25  = {1'b0, p.xb} - {1'b0, p.xa};
            p.sg = p.sb;
          end
          p.am = {23'd0, m25};
          p.zr = (m25 == '0);
        end
      end
      // Normalize add/mul mantissa to bit 23
      if (j == 2 && p.op != OP_DIV) begin
        if (p.op == OP_MUL) begin
          if (p.am[47]) begin
            m24 = p.am[47:24];
            e   = e + 11'sd1;
          end else begin
            m24 = p.am[46:23];
          end
          p.zr = (m24 == '0);
        end else begin
          if (p.am[24]) begin
            m24 = p.am[24:1];
            e   = e + 11'sd1;
          end else begin
            m24 = p.am[23:0];
          end
        end
        lz     = lead_zeros(m24);
        m24    = m24 << lz;
        p.ex   = e - $signed({6'd0, lz});
        p.frac = m24[FRAC_W-1:0];
      end
      // Pack add/mul result
      if (j == 3) begin
        p.res = p.zr ? 32'd0 : pack_word(p.sg, p.ex, p.frac);
      end
      st_nxt[j] = p;
    end
  end

  // Normalize the quotient
  always_comb begin
    pipe_t            p;
    logic [NUM_W-1:0] q;
    logic [4:0]       lz;
    logic [4:0]       tz;
    p  = st_r[DIV_STEPS];
    q  = p.quo;
    lz = '0;
    tz = '0;
    if (p.op == OP_DIV) begin
      if (q[24]) begin
        p.frac = q[23:1];
        p.ex   = p.ex + 11'sd1;
      end else if (q[23]) begin
        p.frac = q[22:0];
      end else if (q[22:0] != 23'd0) begin
        lz     = lead_zeros({1'b0, q[22:0]});
        p.frac = q[22:0] << lz;
        p.ex   = p.ex - $signed({6'd0, lz});
      end else if (q[46:25] != 22'd0) begin
        // only high bits left: the register empties once its lowest one shifts out
        for (int i = 21; i >= 0; i--) begin
          if (q[25+i]) tz = 5'(i);
        end
        p.frac = '0;
        p.ex   = p.ex - 11'sd39 + $signed({6'd0, tz});
      end else begin
        p.frac = '0;
      end
    end
    st_nxt[NST-1] = p;
  end

  // Select the final word
  always_comb begin
    if (st_r[NST-1].op == OP_DIV) begin
      out_data_nxt = st_r[NST-1].dz ? 32'd0
                   : pack_word(st_r[NST-1].sg, st_r[NST-1].ex, st_r[NST-1].frac);
    end else begin
      out_data_nxt = st_r[NST-1].res;
    end
  end

  // Advance all stages together; hold on stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) st_r[i].vld <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      for (int i = 0; i < NST; i++) st_r[i] <= st_nxt[i];
      out_vld_r  <= st_r[NST-1].vld;
      out_data_r <= out_data_nxt;
    end
  end

endmodule
